@@ rtl/core/emas_pkg.sv @@
// shared constants and types for the task-slot scheduler
package emas_pkg;
  localparam int SLOTS = 64;
  localparam int SW = $clog2(SLOTS);
  localparam logic [15:0] AGING_RESET = 16'd800;
  localparam logic signed [31:0] SCORE_CEILING = 32'sh7FFFFFFF;

  localparam logic [1:0] CMD_ROUND = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_LEVEL = 2'd2;
  localparam logic [1:0] CMD_DEAD  = 2'd3;

  localparam logic [1:0] RS_RUNNABLE = 2'd1;
  localparam logic [1:0] RS_RUNNING  = 2'd2;
  localparam logic [1:0] LV_INTER = 2'd1;
  localparam logic [1:0] LV_BATCH = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic init;       // clearing pass: write reset values at scan index
    logic take;       // capture the accepted command word
    logic clear;      // start of a round: reset pick trackers
    logic scan;       // read slot at scan index
    logic direct;     // execute a non-round command
    logic commit;     // write running state of chosen slot
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic last;       // scan index at last slot
  } sts_t;
endpackage

@@ rtl/core/emas_datapath.sv @@
// slot table, round scan logic and result registers
module emas_datapath import emas_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic [1:0]        command,
  input  logic [SW-1:0]     slot,
  input  logic [1:0]        run_state,
  input  logic [1:0]        new_level,
  input  logic signed [31:0] deadline,
  input  logic [31:0]       current_tick,
  input  logic [15:0]       aging_threshold,
  output logic              found,
  output logic [5:0]        selected_slot,
  output logic              status
);
  // slot table, one array per field, registered read
  logic [1:0]  rs_mem [SLOTS];
  logic        rt_mem [SLOTS];
  logic [1:0]  lv_mem [SLOTS];
  logic [31:0] dl_mem [SLOTS];
  logic [15:0] wc_mem [SLOTS];
  logic [1:0]  rs_rd;
  logic        rt_rd;
  logic [1:0]  lv_rd;
  logic [31:0] dl_rd;
  logic [15:0] wc_rd;

  // table ports
  logic [SW-1:0] raddr, waddr;
  logic we_rs, we_rt, we_lv, we_dl, we_wc;
  logic [1:0]  rs_wd, lv_wd;
  logic        rt_wd;
  logic [31:0] dl_wd;
  logic [15:0] wc_wd;

  // captured command word
  logic [1:0]    cmd_q;
  logic [SW-1:0] slot_q;
  logic [1:0]    run_state_q, new_level_q;
  logic [31:0]   deadline_q, tick_q;

  logic [SW-1:0] idx, proc_idx;
  logic proc_v;
  logic signed [31:0] best;
  logic rt_have, in_have, bt_done, bt_have;
  logic [SW-1:0] rt_pick, in_pick, bt_pick;

  logic runn, is_rt, is_in, is_bt;
  logic signed [31:0] score;
  logic [15:0] wc_inc;
  logic bt_promote_scan;

  // slot classification from the read word
  always_comb begin
    runn  = rs_rd == RS_RUNNABLE;
    is_rt = runn && rt_rd;
    is_in = runn && !rt_rd && lv_rd == LV_INTER;
    is_bt = runn && !rt_rd && lv_rd == LV_BATCH;
    score = $signed(dl_rd - tick_q);
    bt_promote_scan = is_bt && !bt_done && wc_rd > aging_threshold;
    wc_inc = (wc_rd == 16'hFFFF) ? wc_rd : wc_rd + 16'd1;
  end

  assign sts.last = idx == SW'(SLOTS - 1);

  // chosen slot by priority
  logic have;
  logic [SW-1:0] pick;
  always_comb begin
    have = rt_have || in_have || bt_have;
    pick = rt_have ? rt_pick : (in_have ? in_pick : bt_pick);
  end

  // command capture at acceptance
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q <= command; slot_q <= slot; run_state_q <= run_state;
      new_level_q <= new_level; deadline_q <= deadline; tick_q <= current_tick;
    end
  end

  // scan index and read pipeline stage
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      idx <= '0;
    end else if (ctl.scan || ctl.init) begin
      idx <= idx + SW'(1);
    end
    if (rst) begin
      proc_v <= 1'b0;
    end else begin
      proc_v <= ctl.scan;
    end
    proc_idx <= idx;
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best <= SCORE_CEILING;
      rt_have <= 1'b0; in_have <= 1'b0; bt_done <= 1'b0; bt_have <= 1'b0;
      rt_pick <= '0; in_pick <= '0; bt_pick <= '0;
    end else if (proc_v) begin
      if (is_rt && score < best) begin
        best <= score; rt_pick <= proc_idx; rt_have <= 1'b1;
      end
      if (is_in && !in_have) begin
        in_pick <= proc_idx; in_have <= 1'b1;
      end
      if (is_bt && !bt_done && !bt_promote_scan) begin
        bt_done <= 1'b1; bt_pick <= proc_idx; bt_have <= 1'b1;
      end
    end
  end

  // table read address
  assign raddr = ctl.take ? slot : idx;

  // table write selection
  always_comb begin
    waddr = proc_idx;
    we_rs = 1'b0; we_rt = 1'b0; we_lv = 1'b0; we_dl = 1'b0; we_wc = 1'b0;
    rs_wd = '0; rt_wd = 1'b0; lv_wd = '0; dl_wd = '0; wc_wd = '0;
    if (ctl.init) begin
      // clearing pass after reset
      waddr = idx;
      we_rs = 1'b1; we_rt = 1'b1; we_lv = 1'b1; we_dl = 1'b1; we_wc = 1'b1;
      lv_wd = LV_BATCH;
    end else if (proc_v) begin
      // batch slot aging; a scan promotion skips the increment
      if (bt_promote_scan) begin
        we_lv = 1'b1; lv_wd = LV_INTER; we_wc = 1'b1;
      end else if (is_bt) begin
        we_wc = 1'b1;
        if (wc_inc > aging_threshold) begin
          we_lv = 1'b1; lv_wd = LV_INTER;
        end else begin
          wc_wd = wc_inc;
        end
      end
    end else if (ctl.commit) begin
      waddr = pick;
      we_rs = have; rs_wd = RS_RUNNING;
    end else if (ctl.direct) begin
      waddr = slot_q;
      unique case (cmd_q)
        CMD_ROUND: ;
        CMD_RUN: begin
          we_rs = 1'b1; rs_wd = run_state_q;
        end
        CMD_LEVEL: if (!rt_rd) begin
          we_lv = 1'b1; lv_wd = new_level_q; we_wc = 1'b1;
        end
        CMD_DEAD: begin
          we_rt = 1'b1; rt_wd = 1'b1; we_dl = 1'b1; dl_wd = deadline_q;
          we_lv = 1'b1; we_wc = 1'b1;
        end
      endcase
    end
  end

  // slot table storage
  always_ff @(posedge clk) begin
    if (we_rs) rs_mem[waddr] <= rs_wd;
    if (we_rt) rt_mem[waddr] <= rt_wd;
    if (we_lv) lv_mem[waddr] <= lv_wd;
    if (we_dl) dl_mem[waddr] <= dl_wd;
    if (we_wc) wc_mem[waddr] <= wc_wd;
    rs_rd <= rs_mem[raddr];
    rt_rd <= rt_mem[raddr];
    lv_rd <= lv_mem[raddr];
    dl_rd <= dl_mem[raddr];
    wc_rd <= wc_mem[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      found <= have;
      selected_slot <= have ? 6'(pick) : 6'd0;
      status <= 1'b0;
    end else if (ctl.direct) begin
      found <= 1'b0;
      selected_slot <= 6'd0;
      status <= (cmd_q == CMD_LEVEL) && rt_rd;
    end
  end
endmodule

@@ rtl/core/emas_ctrl.sv @@
// command sequencer for the scheduler
module emas_ctrl import emas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  sts_t       sts,
  output ctl_t       ctl,
  output logic       busy,
  output logic       done
);
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DIRECT = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0] state, state_next;
  logic       done_next;

  always_comb begin
    state_next = state;
    done_next = 1'b0;
    ctl = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.init = 1'b1;
        if (sts.last) state_next = S_IDLE;
      end
      S_IDLE: if (start) begin
        ctl.take = 1'b1;
        if (command == CMD_ROUND) begin
          ctl.clear = 1'b1; state_next = S_SCAN;
        end else begin
          state_next = S_DIRECT;
        end
      end
      S_DIRECT: begin
        ctl.direct = 1'b1; done_next = 1'b1; state_next = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.last) state_next = S_TAIL;
      end
      // last read word still in the pipeline
      S_TAIL: state_next = S_COMMIT;
      S_COMMIT: begin
        ctl.commit = 1'b1; done_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; done <= 1'b0;
    end else begin
      state <= state_next; done <= done_next;
    end
  end
endmodule

@@ rtl/core/edf_multilevel_aging_scheduler_unit.sv @@
// top level of the multilevel deadline and aging task scheduler
// commands 1 to 3 give their word through the direct state; done is registered
// a round reads one slot a cycle, pipelined, then tail and commit states to its word
// one command at a time; busy holds new starts off
// results show on done for one cycle; the receiver cannot stall
// sync reset sets the threshold to 800; a full table clear follows, busy high
module edf_multilevel_aging_scheduler_unit import emas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [5:0]  slot,
  input  logic [1:0]  run_state,
  input  logic [1:0]  new_level,
  input  logic signed [31:0] deadline,
  input  logic [31:0] current_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        found,
  output logic [5:0]  selected_slot,
  output logic        status
);
  ctl_t ctl;
  sts_t sts;
  logic [15:0] aging_threshold;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) aging_threshold <= AGING_RESET;
    else if (cfg_valid) aging_threshold <= cfg_data;
  end

  emas_ctrl u_ctrl (
    .clk, .rst, .start, .command, .sts, .ctl, .busy, .done
  );

  emas_datapath u_dp (
    .clk, .rst, .ctl, .sts, .command, .slot(slot[SW-1:0]), .run_state, .new_level,
    .deadline, .current_tick, .aging_threshold, .found, .selected_slot, .status
  );
endmodule

@@ rtl/core/emas_checker.sv @@
// port level checks for the scheduler, bound to the top level
module emas_checker import emas_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic found,
  input logic status,
  input logic [1:0] command,
  input logic [5:0] selected_slot
);
  // a non-round command answers with done
  a_direct: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command != CMD_ROUND |-> ##2 done)
    else $error("direct command gave no word");
  // a round raises busy
  a_round: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_ROUND |=> busy)
    else $error("round did not start");
  // refused level change never reports a find
  a_excl: assert property (@(posedge clk) disable iff (rst)
    done && status |-> !found)
    else $error("status and found together");
  // no find means slot zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> selected_slot == 6'd0)
    else $error("slot set without find");
endmodule

bind edf_multilevel_aging_scheduler_unit emas_checker u_chk (
  .clk, .rst, .start, .busy, .done, .found, .status, .command, .selected_slot
);

@@ bench/tb_edf_multilevel_aging_scheduler_unit.sv @@
// testbench for the multilevel deadline and aging task scheduler
`timescale 1ns / 1ps
module tb_edf_multilevel_aging_scheduler_unit;
  import emas_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  slot;
    logic [1:0]  run_state;
    logic [1:0]  new_level;
    logic [31:0] deadline;
    logic [31:0] current_tick;
  } sched_cmd_t;

  typedef struct packed {
    logic       found;
    logic [5:0] selected_slot;
    logic       status;
  } sched_word_t;

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] LV_RT   = 2'd0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = '0;
  logic [5:0] slot = '0;
  logic [1:0] run_state = '0;
  logic [1:0] new_level = '0;
  logic signed [31:0] deadline = '0;
  logic [31:0] current_tick = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic done;
  logic found;
  logic [5:0] selected_slot;
  logic status;

  edf_multilevel_aging_scheduler_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .slot(slot), .run_state(run_state),
    .new_level(new_level), .deadline(deadline), .current_tick(current_tick),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .found(found), .selected_slot(selected_slot), .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow slot table
  logic [15:0] thr;
  logic [1:0]  m_run  [SLOTS];
  logic        m_rt   [SLOTS];
  logic [1:0]  m_lvl  [SLOTS];
  logic [31:0] m_dl   [SLOTS];
  logic [15:0] m_wait [SLOTS];

  sched_cmd_t  pending_cmds[$];
  sched_word_t expected_words[$];
  int mismatch_count = 0;
  bit drain_cfg = 1'b0;

  function automatic void table_reset();
    thr = AGING_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      m_run[i] = RS_IDLE; m_rt[i] = 1'b0; m_lvl[i] = LV_BATCH;
      m_dl[i] = '0; m_wait[i] = '0;
    end
  endfunction

  function automatic logic is_batch(int i);
    return m_run[i] == RS_RUNNABLE && !m_rt[i] && m_lvl[i] == LV_BATCH;
  endfunction

  // compute the word a command produces and update the shadow table
  function automatic sched_word_t schedule_step(sched_cmd_t c);
    sched_word_t w;
    logic have;
    int pick;
    logic signed [31:0] best, score;
    w = '0;
    have = 1'b0;
    pick = 0;
    best = SCORE_CEILING;
    case (c.command)
      CMD_ROUND: begin
        for (int i = 0; i < SLOTS; i++)
          if (m_run[i] == RS_RUNNABLE && m_rt[i]) begin
            score = m_dl[i] - c.current_tick;
            if (score < best) begin
              best = score; pick = i; have = 1'b1;
            end
          end
        if (!have)
          for (int i = 0; i < SLOTS; i++)
            if (!have && m_run[i] == RS_RUNNABLE && !m_rt[i] && m_lvl[i] == LV_INTER) begin
              pick = i; have = 1'b1;
            end
        // batch scan promotes stale slots up to the first fresh one
        for (int i = 0; i < SLOTS; i++) begin
          if (is_batch(i)) begin
            if (m_wait[i] > thr) begin
              m_lvl[i] = LV_INTER; m_wait[i] = '0;
            end else begin
              if (!have) begin
                pick = i; have = 1'b1;
              end
              break;
            end
          end
        end
        // aging of every runnable batch slot
        for (int i = 0; i < SLOTS; i++)
          if (is_batch(i)) begin
            if (m_wait[i] != 16'hFFFF) m_wait[i]++;
            if (m_wait[i] > thr) begin
              m_lvl[i] = LV_INTER; m_wait[i] = '0;
            end
          end
        if (have) m_run[pick] = RS_RUNNING;
        w.found = have;
        w.selected_slot = have ? pick[5:0] : '0;
      end
      CMD_RUN: m_run[c.slot] = c.run_state;
      CMD_LEVEL: begin
        if (m_rt[c.slot]) w.status = 1'b1;
        else begin
          m_lvl[c.slot] = c.new_level; m_wait[c.slot] = '0;
        end
      end
      default: begin
        m_rt[c.slot] = 1'b1; m_dl[c.slot] = c.deadline;
        m_lvl[c.slot] = LV_RT; m_wait[c.slot] = '0;
      end
    endcase
    return w;
  endfunction

  // acceptance seen at the last rising edge
  logic took = 1'b0;

  // driver: one word per accepted start, random gap between words
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (start && took) begin
        start <= 1'b0;
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end else if (!start && !drain_cfg) begin
        if (gap > 0) begin
          gap <= gap - 1;
        end else if (pending_cmds.size() > 0) begin
          sched_cmd_t c;
          c = pending_cmds.pop_front();
          command <= c.command; slot <= c.slot; run_state <= c.run_state;
          new_level <= c.new_level; deadline <= c.deadline;
          current_tick <= c.current_tick;
          start <= 1'b1;
        end
      end
    end
  end

  // acceptance bookkeeping at the rising edge
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      sched_cmd_t c;
      c = '{command, slot, run_state, new_level, deadline, current_tick};
      expected_words.push_back(schedule_step(c));
    end
  end

  // monitor: compare every word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      sched_word_t got, want;
      got = '{found, selected_slot, status};
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected found=%0d slot=%0d status=%0d, got %0d %0d %0d",
                     want.found, want.selected_slot, want.status,
                     got.found, got.selected_slot, got.status);
        end
      end
    end
  end

  function automatic sched_cmd_t random_cmd(int hot);
    sched_cmd_t c;
    int r;
    c.slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, hot));
    c.run_state = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 2));
    c.new_level = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
    c.current_tick = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    c.deadline = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1200);
    r = $urandom_range(0, 99);
    if (r < 30) c.command = CMD_ROUND;
    else if (r < 70) begin
      c.command = CMD_RUN;
      c.run_state = ($urandom_range(0, 2) != 0) ? RS_RUNNABLE : c.run_state;
    end else if (r < 88) c.command = CMD_LEVEL;
    else c.command = CMD_DEAD;
    return c;
  endfunction

  function automatic sched_cmd_t mk(logic [1:0] cm, int s, logic [1:0] rs,
                                    logic [1:0] lv, logic [31:0] dl, logic [31:0] tk);
    return '{cm, 6'(s), rs, lv, dl, tk};
  endfunction

  task automatic write_threshold(logic [15:0] v);
    // wait for the block to go idle
    while (pending_cmds.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
    drain_cfg = 1'b1;
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    thr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    drain_cfg = 1'b0;
  endtask

  initial begin
    logic [15:0] thresholds [5];
    thresholds = '{16'd0, 16'd3, 16'd65535, 16'd40, 16'd800};
    table_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty round, every command, extremes and refusals
    pending_cmds.push_back(mk(CMD_ROUND, 0, '0, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 63, RS_RUNNABLE, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 5, RS_RUNNABLE, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_ROUND, 0, '0, '0, '0, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(CMD_LEVEL, 63, '0, LV_INTER, '0, '0));
    pending_cmds.push_back(mk(CMD_ROUND, 0, '0, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_DEAD, 10, 2'd3, 2'd3, 32'h7FFF_FFFF, '0));
    pending_cmds.push_back(mk(CMD_DEAD, 11, '0, '0, 32'h8000_0000, '0));
    pending_cmds.push_back(mk(CMD_LEVEL, 10, '0, LV_BATCH, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 10, RS_RUNNABLE, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 11, RS_RUNNABLE, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_ROUND, 0, '0, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_ROUND, 0, '0, '0, '0, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_LEVEL, 20, '0, 2'd3, '0, '0));
    pending_cmds.push_back(mk(CMD_LEVEL, 21, '0, 2'd0, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 20, RS_RUNNABLE, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 21, 2'd3, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_RUN, 63, RS_RUNNABLE, '0, '0, '0));
    pending_cmds.push_back(mk(CMD_ROUND, 0, '0, '0, 32'hFFFF_FFFF, 32'h1234_5678));

    // random phases across threshold settings
    foreach (thresholds[p]) begin
      write_threshold(thresholds[p]);
      for (int n = 0; n < 400; n++)
        pending_cmds.push_back(random_cmd(p == 2 ? 63 : 12));
    end
    while (pending_cmds.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("tb_edf_multilevel_aging_scheduler_unit OK");
    else
      $display("tb_edf_multilevel_aging_scheduler_unit NOT OK");
    $finish;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("tb_edf_multilevel_aging_scheduler_unit NOT OK");
    $finish;
  end
endmodule
